@@ hw/rtl/ppt_pkg.sv @@
`timescale 1ns / 1ps

package ppt_pkg;

	localparam int RAW_W    = 10;
	localparam int QFRAC_W  = 16;
	localparam int Q_W      = QFRAC_W + 1;
	localparam int DIV_STEPS = QFRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [Q_W-1:0] QONE      = 17'd65536;
	localparam logic [Q_W-1:0] AGREE_Q   = 17'd6554;
	localparam logic [Q_W-1:0] PRESSED_Q = 17'd16384;
	localparam logic [Q_W-1:0] LOW_Q     = 17'd3277;
	localparam logic [Q_W-1:0] STARTUP_Q = 17'd16384;

	localparam logic [RAW_W-1:0] RAW_MIN_VALID = 10'd5;
	localparam logic [RAW_W-1:0] RAW_MAX_VALID = 10'd1018;

	localparam logic [7:0]  COUNT_SAT = 8'd255;
	localparam logic [15:0] TIMER_SAT = 16'hFFFF;

	localparam logic [RAW_W-1:0] PEDAL_MIN_RST  = 10'd0;
	localparam logic [RAW_W-1:0] PEDAL_MAX_RST  = 10'd1023;
	localparam logic [RAW_W-1:0] HARD_BRAKE_RST = 10'd200;
	localparam logic [7:0]       DIS_LIMIT_RST  = 8'd4;
	localparam logic [15:0]      IMPL_MS_RST    = 16'd1000;
	localparam logic [7:0]       TORQUE_FS_RST  = 8'h90;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEDAL_MIN  = 3'd0,
		REG_PEDAL_MAX  = 3'd1,
		REG_HARD_BRAKE = 3'd2,
		REG_DIS_LIMIT  = 3'd3,
		REG_IMPL_MS    = 3'd4,
		REG_TORQUE_FS  = 3'd5
	} ppt_reg_t;

	typedef struct packed {
		logic capture;
		logic init;
		logic sel_b;
		logic step;
		logic save_a;
		logic commit;
	} ppt_cmd_t;

endpackage

@@ hw/rtl/ppt_ctrl.sv @@
`timescale 1ns / 1ps

module ppt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ppt_pkg::ppt_cmd_t  cmd
);

	localparam int CNT_W = $clog2(ppt_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ppt_pkg::DIV_STEPS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT_A,
		ST_DIV_A,
		ST_INIT_B,
		ST_DIV_B,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             commit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign commit    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.init    = (state_q == ST_INIT_A) || (state_q == ST_INIT_B);
		cmd.sel_b   = (state_q == ST_INIT_B);
		cmd.save_a  = (state_q == ST_INIT_B);
		cmd.step    = (state_q == ST_DIV_A) || (state_q == ST_DIV_B);
		cmd.commit  = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_INIT_A;
				end
				ST_INIT_A: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_A;
				end
				ST_DIV_A: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_INIT_B;
				end
				ST_INIT_B: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_B;
				end
				ST_DIV_B: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/ppt_dp.sv @@
`timescale 1ns / 1ps

module ppt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppt_pkg::ppt_cmd_t                   cmd,
	input  logic                                cfg_we,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [ppt_pkg::RAW_W-1:0]           pedal_a_raw,
	input  logic [ppt_pkg::RAW_W-1:0]           pedal_b_raw,
	input  logic [ppt_pkg::RAW_W-1:0]           brake_a_raw,
	input  logic [ppt_pkg::RAW_W-1:0]           brake_b_raw,
	input  logic                                relay_active,
	input  logic [ppt_pkg::RAW_W-1:0]           elapsed_ms,
	output logic [7:0]                          torque,
	output logic                                enable_pulse,
	output logic                                sensor_fault,
	output logic                                disagree_fault,
	output logic                                brake_fault,
	output logic                                startup_fault,
	output logic                                is_precharged
);

	localparam int RW = ppt_pkg::RAW_W;
	localparam int QW = ppt_pkg::Q_W;
	localparam int FW = ppt_pkg::QFRAC_W;

	// configuration
	logic [RW-1:0] pedal_min_q, pedal_max_q, hard_brake_q;
	logic [7:0]    dis_limit_q, torque_fs_q;
	logic [15:0]   impl_ms_q;

	// captured request
	logic [RW-1:0] pa_q, pb_q, ba_q, bb_q, dt_q;
	logic          relay_q;

	// divider
	logic [RW-1:0] rem_q;
	logic [FW-1:0] quo_q;
	logic [QW-1:0] na_q;

	// block state
	logic        pre_q, sd_q, sl_q, dl_q, bl_q, stl_q, tf_q, es_q;
	logic [15:0] timer_q;
	logic [7:0]  dcnt_q;

	// result
	logic [7:0] torque_q;
	logic       pulse_q, sl_o_q, dl_o_q, bl_o_q, stl_o_q, pre_o_q;

	logic [RW-1:0] span, d_a, d_b;
	logic          span_ok, zero_a, zero_b, full_a, full_b;
	logic [RW:0]   dbl;
	logic          ge;
	logic [QW-1:0] n_a, n_b;

	assign span    = pedal_max_q - pedal_min_q;
	assign span_ok = pedal_max_q > pedal_min_q;
	assign d_a     = pa_q - pedal_min_q;
	assign d_b     = pb_q - pedal_min_q;
	assign zero_a  = !span_ok || (pa_q <= pedal_min_q);
	assign zero_b  = !span_ok || (pb_q <= pedal_min_q);
	assign full_a  = d_a >= span;
	assign full_b  = d_b >= span;
	assign dbl     = {rem_q, 1'b0};
	assign ge      = dbl >= {1'b0, span};

	assign n_a = zero_a ? '0 : (full_a ? ppt_pkg::QONE : {1'b0, quo_q});
	assign n_b = zero_b ? '0 : (full_b ? ppt_pkg::QONE : {1'b0, quo_q});

	// per-request decision, evaluated on commit
	logic [QW:0]   sum;
	logic [QW-1:0] avg, diff;
	logic [16:0]   tsum;
	logic [15:0]   timer_n;
	logic          oor_a, oor_b, hard, pressed, allow, pulse_n;
	logic          pre_n, sd_n, sl_n, dl_n, bl_n, stl_n, tf_n, es_n;
	logic [7:0]    dcnt_n;
	logic [24:0]   prod;
	logic [7:0]    torque_n;

	assign sum   = {1'b0, na_q} + {1'b0, n_b};
	assign avg   = sum[QW:1];
	assign diff  = (na_q > n_b) ? (na_q - n_b) : (n_b - na_q);
	assign oor_a = ((pa_q < ppt_pkg::RAW_MIN_VALID) && (pa_q != '0))
		|| (pa_q > ppt_pkg::RAW_MAX_VALID);
	assign oor_b = ((pb_q < ppt_pkg::RAW_MIN_VALID) && (pb_q != '0))
		|| (pb_q > ppt_pkg::RAW_MAX_VALID);
	assign hard    = (ba_q > hard_brake_q) || (bb_q > hard_brake_q);
	assign pressed = avg > ppt_pkg::PRESSED_Q;
	assign tsum    = {1'b0, timer_q} + {7'd0, dt_q};
	assign prod    = {17'd0, torque_fs_q} * {8'd0, avg};

	always_comb begin
		timer_n  = timer_q;
		pre_n    = pre_q;
		sd_n     = sd_q;
		sl_n     = sl_q;
		dl_n     = dl_q;
		bl_n     = bl_q;
		stl_n    = stl_q;
		tf_n     = tf_q;
		es_n     = es_q;
		dcnt_n   = dcnt_q;
		allow    = 1'b1;
		pulse_n  = 1'b0;
		torque_n = '0;

		if (tf_q)
			timer_n = tsum[16] ? ppt_pkg::TIMER_SAT : tsum[15:0];

		if (relay_q) begin
			if (!pre_q) begin
				pre_n = 1'b1;
				sd_n  = 1'b0;
				stl_n = 1'b0;
			end
		end else if (pre_q) begin
			pre_n = 1'b0;
			es_n  = 1'b0;
			sl_n  = 1'b0;
			dl_n  = 1'b0;
			bl_n  = 1'b0;
			stl_n = 1'b0;
			sd_n  = 1'b0;
		end

		if (oor_a || oor_b)
			sl_n = 1'b1;
		if (sl_n)
			allow = 1'b0;

		if (!sl_n) begin
			if (diff >= ppt_pkg::AGREE_Q) begin
				if (dcnt_n != ppt_pkg::COUNT_SAT)
					dcnt_n = dcnt_n + 8'd1;
				if (dcnt_n >= dis_limit_q)
					dl_n = 1'b1;
			end else begin
				dcnt_n = '0;
				if (dl_n && (avg < ppt_pkg::LOW_Q))
					dl_n = 1'b0;
			end
		end
		if (dl_n)
			allow = 1'b0;

		if (!sl_n && !dl_n) begin
			if (hard && pressed) begin
				if (!tf_n) begin
					tf_n    = 1'b1;
					timer_n = '0;
				end else if (timer_n > impl_ms_q) begin
					bl_n = 1'b1;
				end
			end else begin
				tf_n = 1'b0;
				if (bl_n && (avg < ppt_pkg::LOW_Q))
					bl_n = 1'b0;
			end
		end
		if (bl_n)
			allow = 1'b0;

		if (pre_n && !sd_n && allow) begin
			if (avg > ppt_pkg::STARTUP_Q) begin
				stl_n = 1'b1;
			end else begin
				sd_n  = 1'b1;
				stl_n = 1'b0;
			end
		end
		if (stl_n) begin
			allow = 1'b0;
			if (avg < ppt_pkg::LOW_Q) begin
				stl_n = 1'b0;
				sd_n  = 1'b1;
			end
		end

		if (pre_n && allow) begin
			torque_n = prod[23:16];
			if (!es_n) begin
				pulse_n = 1'b1;
				es_n    = 1'b1;
			end
		end else begin
			es_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedal_min_q  <= ppt_pkg::PEDAL_MIN_RST;
			pedal_max_q  <= ppt_pkg::PEDAL_MAX_RST;
			hard_brake_q <= ppt_pkg::HARD_BRAKE_RST;
			dis_limit_q  <= ppt_pkg::DIS_LIMIT_RST;
			impl_ms_q    <= ppt_pkg::IMPL_MS_RST;
			torque_fs_q  <= ppt_pkg::TORQUE_FS_RST;
			pre_q   <= 1'b0;
			sd_q    <= 1'b0;
			sl_q    <= 1'b0;
			dl_q    <= 1'b0;
			bl_q    <= 1'b0;
			stl_q   <= 1'b0;
			tf_q    <= 1'b0;
			es_q    <= 1'b0;
			timer_q <= '0;
			dcnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ppt_pkg::REG_PEDAL_MIN:  pedal_min_q  <= cfg_data[RW-1:0];
					ppt_pkg::REG_PEDAL_MAX:  pedal_max_q  <= cfg_data[RW-1:0];
					ppt_pkg::REG_HARD_BRAKE: hard_brake_q <= cfg_data[RW-1:0];
					ppt_pkg::REG_DIS_LIMIT:  dis_limit_q  <= cfg_data[7:0];
					ppt_pkg::REG_IMPL_MS:    impl_ms_q    <= cfg_data[15:0];
					ppt_pkg::REG_TORQUE_FS:  torque_fs_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				pre_q   <= pre_n;
				sd_q    <= sd_n;
				sl_q    <= sl_n;
				dl_q    <= dl_n;
				bl_q    <= bl_n;
				stl_q   <= stl_n;
				tf_q    <= tf_n;
				es_q    <= es_n;
				timer_q <= timer_n;
				dcnt_q  <= dcnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pa_q    <= pedal_a_raw;
			pb_q    <= pedal_b_raw;
			ba_q    <= brake_a_raw;
			bb_q    <= brake_b_raw;
			relay_q <= relay_active;
			dt_q    <= elapsed_ms;
		end
		if (cmd.init) begin
			rem_q <= cmd.sel_b ? d_b : d_a;
			quo_q <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? (dbl[RW-1:0] - span) : dbl[RW-1:0];
			quo_q <= {quo_q[FW-2:0], ge};
		end
		if (cmd.save_a)
			na_q <= n_a;
		if (cmd.commit) begin
			torque_q <= torque_n;
			pulse_q  <= pulse_n;
			sl_o_q   <= sl_n;
			dl_o_q   <= dl_n;
			bl_o_q   <= bl_n;
			stl_o_q  <= stl_n;
			pre_o_q  <= pre_n;
		end
	end

	assign torque         = torque_q;
	assign enable_pulse   = pulse_q;
	assign sensor_fault   = sl_o_q;
	assign disagree_fault = dl_o_q;
	assign brake_fault    = bl_o_q;
	assign startup_fault  = stl_o_q;
	assign is_precharged  = pre_o_q;

endmodule

@@ hw/rtl/pedal_plausibility_torque_gate_unit.sv @@
`timescale 1ns / 1ps
// A request is accepted only while idle; the block takes no new request until
// the result of the last one is committed. One shared restoring divider
// normalizes both pedal readings, 16 quotient bits each, one bit a cycle.
// A result waiting in the output register stalls only the final commit.
// Reset (arst_n low) clears all latches, timer, counters and handshake state
// and loads the configuration registers with their default values.

module pedal_plausibility_torque_gate_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ppt_pkg::RAW_W-1:0]          pedal_a_raw,
	input  logic [ppt_pkg::RAW_W-1:0]          pedal_b_raw,
	input  logic [ppt_pkg::RAW_W-1:0]          brake_a_raw,
	input  logic [ppt_pkg::RAW_W-1:0]          brake_b_raw,
	input  logic                               relay_active,
	input  logic [ppt_pkg::RAW_W-1:0]          elapsed_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         torque,
	output logic                               enable_pulse,
	output logic                               sensor_fault,
	output logic                               disagree_fault,
	output logic                               brake_fault,
	output logic                               startup_fault,
	output logic                               is_precharged,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ppt_pkg::ppt_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ppt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ppt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pedal_a_raw    (pedal_a_raw),
		.pedal_b_raw    (pedal_b_raw),
		.brake_a_raw    (brake_a_raw),
		.brake_b_raw    (brake_b_raw),
		.relay_active   (relay_active),
		.elapsed_ms     (elapsed_ms),
		.torque         (torque),
		.enable_pulse   (enable_pulse),
		.sensor_fault   (sensor_fault),
		.disagree_fault (disagree_fault),
		.brake_fault    (brake_fault),
		.startup_fault  (startup_fault),
		.is_precharged  (is_precharged)
	);

endmodule

@@ hw/rtl/ppt_checker.sv @@
`timescale 1ns / 1ps

module ppt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [7:0]                         torque,
	input logic                               enable_pulse,
	input logic                               sensor_fault,
	input logic                               disagree_fault,
	input logic                               brake_fault,
	input logic                               startup_fault,
	input logic                               is_precharged
);

	logic faulted;

	assign faulted = sensor_fault || disagree_fault || brake_fault || startup_fault;

	// a request occupies the engine: no second request the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while engine busy");

	// result is computed first, never shows up right after a request
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> !out_valid)
		else $error("result appeared without computation");

	a_pulse_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && enable_pulse) |-> (is_precharged && !faulted))
		else $error("enable pulse while inhibited");

	a_torque_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (torque != '0)) |-> (is_precharged && !faulted))
		else $error("torque requested while inhibited");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(torque)
			&& $stable(enable_pulse)))
		else $error("stalled result changed");

endmodule

bind pedal_plausibility_torque_gate_unit ppt_checker u_ppt_checker (.*);

@@ tb/tb_pedal_plausibility_torque_gate_unit.sv @@
`timescale 1ns / 1ps

module tb_pedal_plausibility_torque_gate_unit;

	localparam int unsigned TRAVEL_ONE  = 65536;
	localparam int unsigned AGREE_BAND  = 6554;
	localparam int unsigned PRESS_LEVEL = 16384;
	localparam int unsigned LOW_LEVEL   = 3277;
	localparam int unsigned RAW_LO_OK   = 5;
	localparam int unsigned RAW_HI_OK   = 1018;
	localparam int unsigned MS_SAT      = 65535;
	localparam int unsigned COUNT_MAX   = 255;

	typedef struct packed {
		logic [9:0] pa;
		logic [9:0] pb;
		logic [9:0] ba;
		logic [9:0] bb;
		logic       relay;
		logic [9:0] dt;
	} cycle_req_t;

	typedef struct packed {
		logic [7:0] torque;
		logic       pulse;
		logic       sensor;
		logic       disagree;
		logic       brake;
		logic       startup;
		logic       precharged;
	} gate_resp_t;

	class gate_scoreboard;
		int unsigned pedal_min, pedal_max, hard_level, dis_limit, overlap_limit, torque_fs;
		bit precharged, startup_done, sensor_l, disagree_l, brake_l, startup_l;
		bit timing, enable_sent;
		int unsigned overlap_ms, dis_count;
		gate_resp_t expected_q[$];
		int errors;

		function new();
			pedal_min = 0;
			pedal_max = 1023;
			hard_level = 200;
			dis_limit = 4;
			overlap_limit = 1000;
			torque_fs = 144;
			errors = 0;
		endfunction

		function void configure(ppt_pkg::ppt_reg_t idx, logic [15:0] v);
			case (idx)
				ppt_pkg::REG_PEDAL_MIN:  pedal_min = 32'(v[9:0]);
				ppt_pkg::REG_PEDAL_MAX:  pedal_max = 32'(v[9:0]);
				ppt_pkg::REG_HARD_BRAKE: hard_level = 32'(v[9:0]);
				ppt_pkg::REG_DIS_LIMIT:  dis_limit = 32'(v[7:0]);
				ppt_pkg::REG_IMPL_MS:    overlap_limit = 32'(v);
				ppt_pkg::REG_TORQUE_FS:  torque_fs = 32'(v[7:0]);
				default: ;
			endcase
		endfunction

		function int unsigned travel(int unsigned raw);
			int unsigned q;
			if (pedal_max <= pedal_min || raw <= pedal_min)
				return 0;
			q = ((raw - pedal_min) * TRAVEL_ONE) / (pedal_max - pedal_min);
			return (q > TRAVEL_ONE) ? TRAVEL_ONE : q;
		endfunction

		function bit bad_raw(int unsigned raw);
			return (raw < RAW_LO_OK && raw != 0) || raw > RAW_HI_OK;
		endfunction

		function void note_request(cycle_req_t c);
			gate_resp_t r;
			int unsigned na, nb, avg, diff;
			bit allow, hard, pressed;
			r = '0;
			allow = 1'b1;
			if (timing) begin
				overlap_ms += 32'(c.dt);
				if (overlap_ms > MS_SAT)
					overlap_ms = MS_SAT;
			end
			if (c.relay) begin
				if (!precharged) begin
					precharged = 1'b1;
					startup_done = 1'b0;
					startup_l = 1'b0;
				end
			end else if (precharged) begin
				precharged = 1'b0;
				enable_sent = 1'b0;
				sensor_l = 1'b0;
				disagree_l = 1'b0;
				brake_l = 1'b0;
				startup_l = 1'b0;
				startup_done = 1'b0;
			end
			na = travel(32'(c.pa));
			nb = travel(32'(c.pb));
			avg = (na + nb) >> 1;
			diff = (na > nb) ? na - nb : nb - na;

			if (bad_raw(32'(c.pa)) || bad_raw(32'(c.pb)))
				sensor_l = 1'b1;
			if (sensor_l)
				allow = 1'b0;
			if (!sensor_l) begin
				if (diff >= AGREE_BAND) begin
					if (dis_count < COUNT_MAX)
						dis_count++;
					if (dis_count >= dis_limit)
						disagree_l = 1'b1;
				end else begin
					dis_count = 0;
					if (disagree_l && avg < LOW_LEVEL)
						disagree_l = 1'b0;
				end
			end
			if (disagree_l)
				allow = 1'b0;

			hard = 32'(c.ba) > hard_level || 32'(c.bb) > hard_level;
			pressed = avg > PRESS_LEVEL;
			if (!sensor_l && !disagree_l) begin
				if (hard && pressed) begin
					if (!timing) begin
						timing = 1'b1;
						overlap_ms = 0;
					end else if (overlap_ms > overlap_limit) begin
						brake_l = 1'b1;
					end
				end else begin
					timing = 1'b0;
					if (brake_l && avg < LOW_LEVEL)
						brake_l = 1'b0;
				end
			end
			if (brake_l)
				allow = 1'b0;

			if (precharged && !startup_done && allow) begin
				if (avg > PRESS_LEVEL) begin
					startup_l = 1'b1;
				end else begin
					startup_done = 1'b1;
					startup_l = 1'b0;
				end
			end
			if (startup_l) begin
				allow = 1'b0;
				if (avg < LOW_LEVEL) begin
					startup_l = 1'b0;
					startup_done = 1'b1;
				end
			end

			if (precharged && allow) begin
				r.torque = 8'((torque_fs * avg) >> 16);
				if (!enable_sent) begin
					r.pulse = 1'b1;
					enable_sent = 1'b1;
				end
			end else begin
				enable_sent = 1'b0;
			end
			r.sensor = sensor_l;
			r.disagree = disagree_l;
			r.brake = brake_l;
			r.startup = startup_l;
			r.precharged = precharged;
			expected_q.push_back(r);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void compare(string field, logic [7:0] e, logic [7:0] a);
			if (a !== e) begin
				$display("%0t: %s expected %0d actual %0d", $time, field, e, a);
				errors++;
			end
		endfunction

		function void check_response(gate_resp_t got);
			gate_resp_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, torque %0d", $time, got.torque);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare("torque", e.torque, got.torque);
			compare("enable_pulse", 8'(e.pulse), 8'(got.pulse));
			compare("sensor_fault", 8'(e.sensor), 8'(got.sensor));
			compare("disagree_fault", 8'(e.disagree), 8'(got.disagree));
			compare("brake_fault", 8'(e.brake), 8'(got.brake));
			compare("startup_fault", 8'(e.startup), 8'(got.startup));
			compare("is_precharged", 8'(e.precharged), 8'(got.precharged));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [9:0] pedal_a_raw;
	logic [9:0] pedal_b_raw;
	logic [9:0] brake_a_raw;
	logic [9:0] brake_b_raw;
	logic relay_active;
	logic [9:0] elapsed_ms;
	logic out_valid;
	logic out_ready;
	logic [7:0] torque;
	logic enable_pulse;
	logic sensor_fault;
	logic disagree_fault;
	logic brake_fault;
	logic startup_fault;
	logic is_precharged;
	logic cfg_valid;
	logic cfg_ready;
	logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data;

	bit no_stall;
	gate_scoreboard tracker;

	pedal_plausibility_torque_gate_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pedal_a_raw(pedal_a_raw),
		.pedal_b_raw(pedal_b_raw),
		.brake_a_raw(brake_a_raw),
		.brake_b_raw(brake_b_raw),
		.relay_active(relay_active),
		.elapsed_ms(elapsed_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.torque(torque),
		.enable_pulse(enable_pulse),
		.sensor_fault(sensor_fault),
		.disagree_fault(disagree_fault),
		.brake_fault(brake_fault),
		.startup_fault(startup_fault),
		.is_precharged(is_precharged),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_stall)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [9:0] near(int v);
		int r;
		r = v + int'($urandom_range(0, 16)) - 8;
		if (r < 5)
			r = 5;
		if (r > 1018)
			r = 1018;
		return r[9:0];
	endfunction

	task automatic send_cycle(input cycle_req_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pedal_a_raw <= c.pa;
		pedal_b_raw <= c.pb;
		brake_a_raw <= c.ba;
		brake_b_raw <= c.bb;
		relay_active <= c.relay;
		elapsed_ms <= c.dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_request(c);
	endtask

	task automatic req(int pa, int pb, int ba, int bb, int relay, int dt);
		cycle_req_t c;
		c.pa = 10'(pa);
		c.pb = 10'(pb);
		c.ba = 10'(ba);
		c.bb = 10'(bb);
		c.relay = 1'(relay);
		c.dt = 10'(dt);
		send_cycle(c);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(ppt_pkg::ppt_reg_t idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.configure(idx, v);
	endtask

	task automatic program_gate(logic [9:0] pmin, logic [9:0] pmax, logic [9:0] hard,
			logic [7:0] lim, logic [15:0] ms, logic [7:0] fs);
		drain_results();
		write_reg(ppt_pkg::REG_PEDAL_MIN, 16'(pmin));
		write_reg(ppt_pkg::REG_PEDAL_MAX, 16'(pmax));
		write_reg(ppt_pkg::REG_HARD_BRAKE, 16'(hard));
		write_reg(ppt_pkg::REG_DIS_LIMIT, 16'(lim));
		write_reg(ppt_pkg::REG_IMPL_MS, ms);
		write_reg(ppt_pkg::REG_TORQUE_FS, 16'(fs));
		cfg_valid <= 1'b0;
	endtask

	// episodes of driving, brake overlap, disagreement, release, relay cycling and noise
	task automatic random_run(int n);
		int sent, len, mode, base, k;
		cycle_req_t c;
		sent = 0;
		while (sent < n) begin
			mode = $urandom_range(0, 99);
			len = $urandom_range(3, 30);
			base = $urandom_range(5, 1018);
			for (k = 0; k < len && sent < n; k++) begin
				c.relay = ($urandom_range(0, 39) != 0);
				c.dt = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
					10'($urandom_range(10, 50));
				c.ba = 10'($urandom_range(0, 150));
				c.bb = 10'($urandom_range(0, 150));
				if (mode < 45) begin
					c.pa = near(base);
					c.pb = near(base);
				end else if (mode < 65) begin
					c.pa = near(base | 400);
					c.pb = near(base | 400);
					c.ba = 10'($urandom_range(0, 1023));
					c.bb = 10'($urandom_range(0, 1023));
				end else if (mode < 75) begin
					c.pa = 10'($urandom_range(0, 1018));
					c.pb = 10'($urandom_range(0, 1018));
				end else if (mode < 85) begin
					c.pa = ($urandom_range(0, 1) != 0) ? 10'd0 : 10'($urandom_range(5, 40));
					c.pb = ($urandom_range(0, 1) != 0) ? 10'd0 : 10'($urandom_range(5, 40));
				end else if (mode < 92) begin
					c.pa = near(base);
					c.pb = near(base);
					c.relay = 1'($urandom_range(0, 1));
				end else begin
					c = {19'd0, $urandom};
					c.pa = 10'($urandom_range(0, 1023));
					c.pb = 10'($urandom_range(0, 1023));
					c.dt = 10'($urandom_range(0, 1023));
				end
				send_cycle(c);
				sent++;
				if ($urandom_range(0, 79) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int run, gap;
			run = $urandom_range(1, 20);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_response({torque, enable_pulse, sensor_fault, disagree_fault,
				brake_fault, startup_fault, is_precharged});
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pedal_a_raw = '0;
		pedal_b_raw = '0;
		brake_a_raw = '0;
		brake_b_raw = '0;
		relay_active = 1'b0;
		elapsed_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = ppt_pkg::REG_PEDAL_MIN;
		cfg_data = '0;
		no_stall = 1'b0;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		req(0, 0, 0, 0, 0, 0);
		req(0, 0, 0, 0, 1, 30);
		req(1018, 1018, 0, 0, 1, 30);
		// hard brake with pedal: timer starts, then exceeds limit
		req(512, 520, 1023, 0, 1, 1023);
		req(512, 520, 0, 1023, 1, 1023);
		req(0, 0, 0, 0, 1, 0);
		repeat (4) req(600, 0, 0, 0, 1, 10);
		req(100, 100, 0, 0, 1, 10);
		req(0, 0, 0, 0, 1, 10);
		req(1, 0, 0, 0, 1, 10);
		req(0, 0, 0, 0, 0, 0);
		// pedal pressed when relay comes up
		req(700, 700, 0, 0, 1, 30);
		req(100, 100, 0, 0, 1, 30);
		req(1019, 5, 0, 0, 1, 30);
		req(1023, 1023, 1023, 1023, 0, 1023);
		req(0, 0, 0, 0, 0, 0);
		req(5, 5, 0, 0, 1, 1);
		req(0, 0, 0, 0, 0, 1);
		req(5, 4, 0, 0, 1, 20);
		req(0, 0, 0, 0, 0, 20);
		req(5, 5, 0, 0, 1, 20);

		program_gate(10'd0, 10'd1023, 10'd0, 8'd1, 16'd0, 8'd255);
		random_run(120);
		program_gate(10'd1023, 10'd0, 10'd1023, 8'd255, 16'd65535, 8'd0);
		random_run(50);
		program_gate(10'd100, 10'd900, 10'd512, 8'd0, 16'd65535, 8'd200);
		random_run(100);
		for (int p = 0; p < 5; p++) begin
			program_gate(10'($urandom_range(0, 300)),
				($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023)) :
					10'($urandom_range(500, 1023)),
				10'($urandom_range(0, 1023)),
				($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
					8'($urandom_range(1, 12)),
				($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) :
					16'($urandom_range(0, 400)),
				8'($urandom_range(0, 255)));
			no_stall = (p == 2);
			random_run(110);
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_ctrl.sv
hw/rtl/ppt_dp.sv
hw/rtl/pedal_plausibility_torque_gate_unit.sv
hw/rtl/ppt_checker.sv
tb/tb_pedal_plausibility_torque_gate_unit.sv
